### rtl/kprt_pkg.sv
package kprt_pkg;

    // Command codes on the input channel
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_RETIRE = 2'd2;

    // Request queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Result field widths fixed by the interface
    localparam int IDX_OUT_W    = 4;
    localparam int ROUND_W      = 32;
    localparam int SECRET_OUT_W = 64;

    // Classified command: what the back part has to do
    typedef struct packed {
        logic ins;   // insert new entry
        logic srch;  // search newest matching slot
        logic clr;   // clear the matched slot
    } cls_t;

    function automatic cls_t classify(input logic [1:0] cmd);
        cls_t c;
        c = '0;
        case (cmd)
            CMD_INSERT: c.ins  = 1'b1;
            CMD_LOOKUP: c.srch = 1'b1;
            CMD_RETIRE:
            begin
                c.srch = 1'b1;
                c.clr  = 1'b1;
            end
            default:    c = '0;
        endcase
        return c;
    endfunction

endpackage

### rtl/keyed_pending_round_table.sv
// Keyed pending round table: a table of SLOTS entries (key, round, secret).
// Input channel (in_valid/in_ready) carries one request: cmd 0 inserts,
// 1 looks up the newest round for a key, 2 does the same and retires that
// slot; cmd 3 leaves the table alone and returns an all-zero result.
// Output channel (out_valid/out_ready) returns exactly one result per
// request, in request order.
// A two-entry request queue takes requests while the table is busy.
// The table sequencer handles one request at a time: a match step, then
// an insert step, or for lookup/retire a scan of one slot per cycle for the
// newest match followed by a finish step; cmd 3 ends after the match step.
// The result is loaded into the output register from that last step.
// When the receiver stalls, the result waits in the output register, the
// queue fills, and in_ready drops once both queue entries are held.
// Reset clears every active bit, the queue and the output valid flag.
module keyed_pending_round_table #(
    parameter int SLOTS       = 16,
    parameter int KEY_BITS    = 64,
    parameter int SECRET_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [63:0] key,
    input  logic [31:0] round_number,
    input  logic [63:0] secret_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [3:0]  slot_index,
    output logic [31:0] found_round,
    output logic [63:0] secret_out,
    output logic        replaced_same_key,
    output logic        evicted_oldest
);

    logic                   q_valid;
    logic                   q_ready;
    kprt_pkg::cls_t         q_cls;
    logic [KEY_BITS-1:0]    q_key;
    logic [31:0]            q_round;
    logic [SECRET_BITS-1:0] q_secret;

    kprt_front #(
        .KEY_BITS    (KEY_BITS),
        .SECRET_BITS (SECRET_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .key          (key),
        .round_number (round_number),
        .secret_word  (secret_word),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_cls        (q_cls),
        .q_key        (q_key),
        .q_round      (q_round),
        .q_secret     (q_secret)
    );

    kprt_back #(
        .SLOTS       (SLOTS),
        .KEY_BITS    (KEY_BITS),
        .SECRET_BITS (SECRET_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_ready           (q_ready),
        .q_cls             (q_cls),
        .q_key             (q_key),
        .q_round           (q_round),
        .q_secret          (q_secret),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .found             (found),
        .slot_index        (slot_index),
        .found_round       (found_round),
        .secret_out        (secret_out),
        .replaced_same_key (replaced_same_key),
        .evicted_oldest    (evicted_oldest)
    );

endmodule

### rtl/kprt_front.sv
module kprt_front #(
    parameter int KEY_BITS    = 64,
    parameter int SECRET_BITS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             cmd,
    input  logic [63:0]            key,
    input  logic [31:0]            round_number,
    input  logic [63:0]            secret_word,
    output logic                   q_valid,
    input  logic                   q_ready,
    output kprt_pkg::cls_t         q_cls,
    output logic [KEY_BITS-1:0]    q_key,
    output logic [31:0]            q_round,
    output logic [SECRET_BITS-1:0] q_secret
);

    kprt_pkg::cls_t         cls_mem    [kprt_pkg::Q_DEPTH];
    logic [KEY_BITS-1:0]    key_mem    [kprt_pkg::Q_DEPTH];
    logic [31:0]            round_mem  [kprt_pkg::Q_DEPTH];
    logic [SECRET_BITS-1:0] secret_mem [kprt_pkg::Q_DEPTH];

    logic [kprt_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [kprt_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [kprt_pkg::Q_CNT_W-1:0] count_reg, count_next;
    logic                         push;
    logic                         pop;

    // Accept while the queue has room
    assign in_ready = (count_reg != kprt_pkg::Q_CNT_W'(kprt_pkg::Q_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_valid && q_ready;

    assign q_cls    = cls_mem[rd_ptr_reg];
    assign q_key    = key_mem[rd_ptr_reg];
    assign q_round  = round_mem[rd_ptr_reg];
    assign q_secret = secret_mem[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Classify and narrow the request on the way in
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cls_mem[wr_ptr_reg]    <= kprt_pkg::classify(cmd);
            key_mem[wr_ptr_reg]    <= key[KEY_BITS-1:0];
            round_mem[wr_ptr_reg]  <= round_number;
            secret_mem[wr_ptr_reg] <= secret_word[SECRET_BITS-1:0];
        end
    end

endmodule

### rtl/kprt_back.sv
module kprt_back #(
    parameter int SLOTS       = 16,
    parameter int KEY_BITS    = 64,
    parameter int SECRET_BITS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  kprt_pkg::cls_t         q_cls,
    input  logic [KEY_BITS-1:0]    q_key,
    input  logic [31:0]            q_round,
    input  logic [SECRET_BITS-1:0] q_secret,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   found,
    output logic [3:0]             slot_index,
    output logic [31:0]            found_round,
    output logic [63:0]            secret_out,
    output logic                   replaced_same_key,
    output logic                   evicted_oldest
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MATCH = 3'd1;
    localparam logic [2:0] ST_INS   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    // Slot table
    logic [SLOTS-1:0]       active_reg, active_next;
    logic [KEY_BITS-1:0]    key_reg    [SLOTS];
    logic [31:0]            round_reg  [SLOTS];
    logic [SECRET_BITS-1:0] secret_reg [SLOTS];

    // Sequencer
    logic [2:0]             state_reg, state_next;
    kprt_pkg::cls_t         cur_cls_reg;
    logic [KEY_BITS-1:0]    cur_key_reg;
    logic [31:0]            cur_round_reg;
    logic [SECRET_BITS-1:0] cur_secret_reg;
    logic [SLOTS-1:0]       match_reg;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   best_v_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [31:0]            best_round_reg;
    logic [SECRET_BITS-1:0] best_secret_reg;

    // Result stage
    logic                   res_valid_reg, res_valid_next;
    logic                   res_found_reg;
    logic [3:0]             res_idx_reg;
    logic [31:0]            res_round_reg;
    logic [63:0]            res_secret_reg;
    logic                   res_repl_reg;
    logic                   res_evict_reg;

    logic                   pop;
    logic                   res_load;
    logic [SLOTS-1:0]       kept;
    logic [IDX_W-1:0]       ins_slot;
    logic                   ins_free;
    logic                   scan_hit;
    logic                   scan_last;
    logic [7:0]             ins_slot_w;
    logic [7:0]             best_idx_w;

    // Take a request only when idle and the result stage will be free
    assign q_ready = (state_reg == ST_IDLE) && (!res_valid_reg || out_ready);
    assign pop     = q_valid && q_ready;

    // Drop equal-key slots and find the lowest free one
    always_comb
    begin
        kept     = active_reg & ~match_reg;
        ins_slot = IDX_W'(SLOTS - 1);
        ins_free = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!kept[i])
            begin
                ins_slot = IDX_W'(i);
                ins_free = 1'b1;
            end
        end
    end

    // Scan one slot per cycle for the newest match
    assign scan_hit  = match_reg[idx_reg]
                       && (!best_v_reg || (round_reg[idx_reg] > best_round_reg));
    assign scan_last = (idx_reg == IDX_W'(SLOTS - 1));

    assign ins_slot_w = 8'(ins_slot);
    assign best_idx_w = 8'(best_idx_reg);

    // Next state, active bits and result load
    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        idx_next       = '0;
        res_load       = 1'b0;
        res_valid_next = res_valid_reg;
        if (res_valid_reg && out_ready)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                if (cur_cls_reg.ins)
                begin
                    state_next = ST_INS;
                end
                else if (cur_cls_reg.srch)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_INS:
            begin
                if (ins_free)
                begin
                    active_next           = kept;
                    active_next[ins_slot] = 1'b1;
                end
                else
                begin
                    active_next = {1'b1, kept[SLOTS-1:1]};
                end
                res_load   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                if (cur_cls_reg.clr && best_v_reg)
                begin
                    active_next[best_idx_reg] = 1'b0;
                end
                res_load   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
            best_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
            if (state_reg == ST_MATCH)
            begin
                best_v_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN && scan_hit)
            begin
                best_v_reg <= 1'b1;
            end
        end
    end

    // Latch the request and its match vector, track the best slot
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_cls_reg    <= q_cls;
            cur_key_reg    <= q_key;
            cur_round_reg  <= q_round;
            cur_secret_reg <= q_secret;
        end
        if (state_reg == ST_MATCH)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                match_reg[i] <= active_reg[i] && (key_reg[i] == cur_key_reg);
            end
        end
        if (state_reg == ST_SCAN && scan_hit)
        begin
            best_idx_reg    <= idx_reg;
            best_round_reg  <= round_reg[idx_reg];
            best_secret_reg <= secret_reg[idx_reg];
        end
    end

    // Write or shift the slot payload on insert
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_INS)
        begin
            if (ins_free)
            begin
                key_reg[ins_slot]    <= cur_key_reg;
                round_reg[ins_slot]  <= cur_round_reg;
                secret_reg[ins_slot] <= cur_secret_reg;
            end
            else
            begin
                for (int i = 0; i < SLOTS - 1; i++)
                begin
                    key_reg[i]    <= key_reg[i+1];
                    round_reg[i]  <= round_reg[i+1];
                    secret_reg[i] <= secret_reg[i+1];
                end
                key_reg[SLOTS-1]    <= cur_key_reg;
                round_reg[SLOTS-1]  <= cur_round_reg;
                secret_reg[SLOTS-1] <= cur_secret_reg;
            end
        end
    end

    // Load the result stage
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_found_reg  <= 1'b0;
            res_idx_reg    <= '0;
            res_round_reg  <= '0;
            res_secret_reg <= '0;
            res_repl_reg   <= 1'b0;
            res_evict_reg  <= 1'b0;
            if (state_reg == ST_INS)
            begin
                res_found_reg <= 1'b1;
                res_idx_reg   <= ins_free ? ins_slot_w[3:0] : 4'(SLOTS - 1);
                res_round_reg <= cur_round_reg;
                res_repl_reg  <= |match_reg;
                res_evict_reg <= !ins_free;
            end
            else if (state_reg == ST_FIN && best_v_reg)
            begin
                res_found_reg  <= 1'b1;
                res_idx_reg    <= best_idx_w[3:0];
                res_round_reg  <= best_round_reg;
                res_secret_reg <= 64'(best_secret_reg);
            end
        end
    end

    assign out_valid         = res_valid_reg;
    assign found             = res_found_reg;
    assign slot_index        = res_idx_reg;
    assign found_round       = res_round_reg;
    assign secret_out        = res_secret_reg;
    assign replaced_same_key = res_repl_reg;
    assign evicted_oldest    = res_evict_reg;

`ifndef SYNTH
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_repl_reg && res_evict_reg))
        else $error("insert reported both replace and evict");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_found_reg) |->
        (res_idx_reg == '0 && res_round_reg == '0 && res_secret_reg == '0))
        else $error("miss result carries nonzero fields");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SCAN) |-> (idx_reg == '0))
        else $error("scan index moved outside scan");

    a_retire_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && cur_cls_reg.clr && best_v_reg) |=>
        !active_reg[$past(best_idx_reg)])
        else $error("retire left the matched slot active");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !q_ready)
        else $error("request taken while sequencer busy");
`endif

endmodule
